>>> src/xte_pkg.sv
`timescale 1ns / 1ps

package xte_pkg;

   // Block geometry and frame layout.
   localparam int BLOCK_BYTES = 128;
   localparam int BUF_IDX_W   = $clog2(BLOCK_BYTES);
   localparam int FRAME_LEN   = BLOCK_BYTES + 4;
   localparam int CURSOR_W    = $clog2(FRAME_LEN + 1);
   localparam int DATA_FIRST  = 4;

   // Line control characters.
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ESC = 8'h1B;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_NAK_INTERVAL = 2'd0,
      CSR_NAK_TRIES    = 2'd1,
      CSR_SEND_START   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ACT_START_RX = 3'd0,
      ACT_START_TX = 3'd1,
      ACT_LINE     = 3'd2,
      ACT_TICK     = 3'd3,
      ACT_PULL     = 3'd4,
      ACT_WRITE    = 3'd5,
      ACT_READ     = 3'd6,
      ACT_VERDICT  = 3'd7
   } action_type;

   typedef enum logic [3:0] {
      MODE_OFF,
      MODE_RX_INIT,
      MODE_RX_WAIT,
      MODE_RX_FN1,
      MODE_RX_FN2,
      MODE_RX_DATA,
      MODE_RX_PROCESS,
      MODE_RX_VERDICT,
      MODE_TX_INIT,
      MODE_TX_WAIT,
      MODE_TX_NEED,
      MODE_TX_EOT
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_RECEIVED  = 3'd1,
      EV_NEEDED    = 3'd2,
      EV_FINISHED  = 3'd3,
      EV_CANCELLED = 3'd4,
      EV_TIMEOUT   = 3'd5
   } event_type;

   // Source of the line byte of a result.
   typedef enum logic [1:0] {
      TXS_NONE,
      TXS_BYTE,
      TXS_DATA,
      TXS_SUM
   } tx_sel_type;

   // Result record handed from the control stage to the response stage.
   typedef struct packed {
      tx_sel_type  tx_sel;
      logic [7:0]  tx_byte;
      logic        last;
      logic        dual;
      event_type   ev;
      logic [31:0] addr;
      logic        rd_sel;
      logic        accepted;
      logic        busy;
      logic        sum_clear;
   } rsp_rec_type;

   // Block store access issued by the control stage.
   typedef struct packed {
      logic                 wr_en;
      logic [BUF_IDX_W-1:0] wr_addr;
      logic [7:0]           wr_data;
      logic                 rd_en;
      logic [BUF_IDX_W-1:0] rd_addr;
   } mem_cmd_type;

endpackage

>>> src/xte_block_ram.sv
`timescale 1ns / 1ps

module xte_block_ram (
   input  logic               clock,
   input  xte_pkg::mem_cmd_type cmd,
   output logic [7:0]         rd_data
);
   import xte_pkg::*;

   logic [7:0] mem_ff [BLOCK_BYTES];
   logic [7:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/xte_ctrl.sv
`timescale 1ns / 1ps

module xte_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [2:0]            action,
   input  logic [7:0]            line_data,
   input  logic                  app_ok,
   input  logic [xte_pkg::BUF_IDX_W-1:0] buf_index,
   input  logic [7:0]            buf_data,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data,
   output xte_pkg::rsp_rec_type  rec,
   output xte_pkg::mem_cmd_type  mem_cmd
);
   import xte_pkg::*;

   // Configuration registers.
   logic [15:0] nak_interval_ff;
   logic [7:0]  nak_tries_ff;
   logic [15:0] send_start_ff;

   // Session state.
   mode_type              mode_ff, mode_in;
   logic [7:0]            expected_ff, expected_in;
   logic [7:0]            got_ff, got_in;
   logic [7:0]            rx_sum_ff, rx_sum_in;
   logic [7:0]            tries_ff, tries_in;
   logic [15:0]           tick_ff, tick_in;
   logic [BUF_IDX_W-1:0]  fill_ff, fill_in;
   logic [31:0]           offset_ff, offset_in;
   logic [CURSOR_W-1:0]   cursor_ff, cursor_in;

   action_type act;
   logic       line_live;
   logic       nak_at_init;
   logic [7:0] tx_b;
   logic       fill_done;

   assign act         = action_type'(action);
   assign line_live   = (cursor_ff == '0) && (mode_ff != MODE_RX_VERDICT)
                        && (mode_ff != MODE_TX_NEED);
   // In the sender start phase the first NAK counts as an ACK.
   assign nak_at_init = (mode_ff == MODE_TX_INIT) && (line_data == CH_NAK);
   assign tx_b        = nak_at_init ? CH_ACK : line_data;
   assign fill_done   = (fill_ff == BUF_IDX_W'(BLOCK_BYTES - 1));

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         nak_interval_ff <= 16'd5;
         nak_tries_ff    <= 8'd60;
         send_start_ff   <= 16'd300;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NAK_INTERVAL: nak_interval_ff <= csr_data;
            CSR_NAK_TRIES:    nak_tries_ff    <= csr_data[7:0];
            CSR_SEND_START:   send_start_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Next protocol mode.
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         unique case (act)
            ACT_START_RX: mode_in = MODE_RX_INIT;
            ACT_START_TX: mode_in = MODE_TX_INIT;
            ACT_LINE: begin
               if (mode_ff != MODE_OFF && line_live) begin
                  unique case (mode_ff) inside
                     MODE_RX_INIT, MODE_RX_WAIT: begin
                        if (line_data == CH_SOH) begin
                           mode_in = MODE_RX_FN1;
                        end else if (line_data == CH_EOT || line_data == CH_CAN
                                     || line_data == CH_ESC) begin
                           mode_in = MODE_OFF;
                        end
                     end
                     MODE_RX_FN1: mode_in = MODE_RX_FN2;
                     MODE_RX_FN2: begin
                        mode_in = (line_data == ~got_ff) ? MODE_RX_DATA : MODE_RX_WAIT;
                     end
                     MODE_RX_DATA: begin
                        if (fill_done) begin
                           mode_in = MODE_RX_PROCESS;
                        end
                     end
                     MODE_RX_PROCESS: begin
                        if (got_ff == expected_ff) begin
                           mode_in = (rx_sum_ff == line_data) ? MODE_RX_VERDICT
                                                              : MODE_RX_WAIT;
                        end else if (got_ff == expected_ff - 8'd1) begin
                           mode_in = MODE_RX_WAIT;
                        end else begin
                           mode_in = MODE_OFF;
                        end
                     end
                     MODE_TX_INIT, MODE_TX_WAIT: begin
                        if (mode_ff == MODE_TX_INIT && line_data == CH_ESC) begin
                           mode_in = MODE_OFF;
                        end else if (tx_b == CH_CAN) begin
                           mode_in = MODE_OFF;
                        end else if (tx_b == CH_ACK) begin
                           mode_in = MODE_TX_NEED;
                        end
                     end
                     MODE_TX_EOT: mode_in = MODE_OFF;
                     default: ;
                  endcase
               end
            end
            ACT_TICK: begin
               if (mode_ff == MODE_RX_INIT && tick_ff == '0 && tries_ff == '0) begin
                  mode_in = MODE_OFF;
               end else if (mode_ff == MODE_TX_INIT && tick_ff == '0) begin
                  mode_in = MODE_OFF;
               end
            end
            ACT_VERDICT: begin
               if (mode_ff == MODE_RX_VERDICT) begin
                  mode_in = app_ok ? MODE_RX_WAIT : MODE_OFF;
               end else if (mode_ff == MODE_TX_NEED) begin
                  mode_in = app_ok ? MODE_TX_WAIT : MODE_TX_EOT;
               end
            end
            default: ;
         endcase
      end
   end

   // Datapath updates, block store access and the result record.
   always_comb begin
      expected_in = expected_ff;
      got_in      = got_ff;
      rx_sum_in   = rx_sum_ff;
      tries_in    = tries_ff;
      tick_in     = tick_ff;
      fill_in     = fill_ff;
      offset_in   = offset_ff;
      cursor_in   = cursor_ff;

      rec           = '0;
      rec.tx_sel    = TXS_NONE;
      rec.last      = 1'b1;
      rec.ev        = EV_NONE;
      rec.accepted  = 1'b1;
      rec.busy      = (mode_in != MODE_OFF);

      mem_cmd         = '0;
      mem_cmd.wr_data = line_data;

      if (accept) begin
         unique case (act)
            ACT_START_RX: begin
               expected_in = 8'd1;
               tries_in    = nak_tries_ff;
               tick_in     = nak_interval_ff;
               offset_in   = '0;
               cursor_in   = '0;
            end
            ACT_START_TX: begin
               tick_in   = send_start_ff;
               offset_in = '0;
               cursor_in = '0;
            end
            ACT_LINE: begin
               if (mode_ff == MODE_OFF) begin
                  rec.accepted = 1'b0;
               end else if (line_live) begin
                  unique case (mode_ff) inside
                     MODE_RX_INIT, MODE_RX_WAIT: begin
                        if (line_data == CH_SOH) begin
                           fill_in   = '0;
                           rx_sum_in = '0;
                        end else if (line_data == CH_EOT) begin
                           rec.tx_sel  = TXS_BYTE;
                           rec.tx_byte = CH_ACK;
                           rec.ev      = EV_FINISHED;
                        end else if (line_data == CH_CAN || line_data == CH_ESC) begin
                           rec.ev = EV_CANCELLED;
                        end
                     end
                     MODE_RX_FN1: got_in = line_data;
                     MODE_RX_FN2: begin
                        if (line_data != ~got_ff) begin
                           rec.tx_sel  = TXS_BYTE;
                           rec.tx_byte = CH_NAK;
                        end
                     end
                     MODE_RX_DATA: begin
                        mem_cmd.wr_en   = 1'b1;
                        mem_cmd.wr_addr = fill_ff;
                        rx_sum_in       = rx_sum_ff + line_data;
                        fill_in         = fill_ff + 1'b1;
                     end
                     MODE_RX_PROCESS: begin
                        if (got_ff == expected_ff) begin
                           if (rx_sum_ff == line_data) begin
                              rec.ev   = EV_RECEIVED;
                              rec.addr = offset_ff;
                           end else begin
                              rec.tx_sel  = TXS_BYTE;
                              rec.tx_byte = CH_NAK;
                           end
                        end else if (got_ff == expected_ff - 8'd1) begin
                           rec.tx_sel  = TXS_BYTE;
                           rec.tx_byte = CH_ACK;
                        end else begin
                           rec.tx_sel  = TXS_BYTE;
                           rec.tx_byte = CH_CAN;
                           rec.ev      = EV_CANCELLED;
                        end
                     end
                     MODE_TX_INIT, MODE_TX_WAIT: begin
                        if (mode_ff == MODE_TX_INIT && line_data == CH_ESC) begin
                           rec.ev = EV_CANCELLED;
                        end else if (tx_b == CH_CAN) begin
                           rec.tx_sel  = TXS_BYTE;
                           rec.tx_byte = CH_ACK;
                           rec.ev      = EV_CANCELLED;
                        end else if (tx_b == CH_ACK) begin
                           // The first NAK restarts numbering at one.
                           expected_in = nak_at_init ? 8'd1 : expected_ff + 8'd1;
                           rec.ev      = EV_NEEDED;
                           rec.addr    = offset_ff;
                        end else if (tx_b == CH_NAK) begin
                           cursor_in     = CURSOR_W'(1);
                           rec.sum_clear = 1'b1;
                        end
                     end
                     MODE_TX_EOT: rec.ev = EV_FINISHED;
                     default: ;
                  endcase
               end
            end
            ACT_TICK: begin
               if (mode_ff == MODE_RX_INIT) begin
                  if (tick_ff == '0) begin
                     if (tries_ff != '0) begin
                        tries_in    = tries_ff - 8'd1;
                        rec.tx_sel  = TXS_BYTE;
                        rec.tx_byte = CH_NAK;
                     end else begin
                        rec.ev = EV_TIMEOUT;
                     end
                     tick_in = nak_interval_ff;
                  end else begin
                     tick_in = tick_ff - 16'd1;
                  end
               end else if (mode_ff == MODE_TX_INIT) begin
                  if (tick_ff == '0) begin
                     rec.ev = EV_TIMEOUT;
                  end else begin
                     tick_in = tick_ff - 16'd1;
                  end
               end
            end
            ACT_PULL: begin
               if (cursor_ff != '0) begin
                  rec.last = 1'b0;
                  if (cursor_ff == CURSOR_W'(1)) begin
                     rec.tx_sel  = TXS_BYTE;
                     rec.tx_byte = CH_SOH;
                  end else if (cursor_ff == CURSOR_W'(2)) begin
                     rec.tx_sel  = TXS_BYTE;
                     rec.tx_byte = expected_ff;
                  end else if (cursor_ff == CURSOR_W'(3)) begin
                     rec.tx_sel  = TXS_BYTE;
                     rec.tx_byte = ~expected_ff;
                  end else if (cursor_ff < CURSOR_W'(FRAME_LEN)) begin
                     rec.tx_sel      = TXS_DATA;
                     mem_cmd.rd_en   = 1'b1;
                     mem_cmd.rd_addr = BUF_IDX_W'(cursor_ff - CURSOR_W'(DATA_FIRST));
                  end else begin
                     rec.tx_sel = TXS_SUM;
                     rec.last   = 1'b1;
                  end
                  cursor_in = rec.last ? '0 : cursor_ff + 1'b1;
               end
            end
            ACT_WRITE: begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = buf_index;
               mem_cmd.wr_data = buf_data;
            end
            ACT_READ: begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = buf_index;
               rec.rd_sel      = 1'b1;
            end
            ACT_VERDICT: begin
               if (mode_ff == MODE_RX_VERDICT) begin
                  rec.tx_sel = TXS_BYTE;
                  if (app_ok) begin
                     expected_in = expected_ff + 8'd1;
                     offset_in   = offset_ff + 32'(BLOCK_BYTES);
                     rec.tx_byte = CH_ACK;
                  end else begin
                     // A refused block is answered with two CAN bytes.
                     rec.tx_byte = CH_CAN;
                     rec.dual    = 1'b1;
                     rec.ev      = EV_CANCELLED;
                  end
               end else if (mode_ff == MODE_TX_NEED) begin
                  if (app_ok) begin
                     cursor_in     = CURSOR_W'(1);
                     rec.sum_clear = 1'b1;
                     offset_in     = offset_ff + 32'(BLOCK_BYTES);
                  end else begin
                     rec.tx_sel  = TXS_BYTE;
                     rec.tx_byte = CH_EOT;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_OFF;
         expected_ff <= '0;
         got_ff      <= '0;
         rx_sum_ff   <= '0;
         tries_ff    <= '0;
         tick_ff     <= '0;
         fill_ff     <= '0;
         offset_ff   <= '0;
         cursor_ff   <= '0;
      end else begin
         mode_ff     <= mode_in;
         expected_ff <= expected_in;
         got_ff      <= got_in;
         rx_sum_ff   <= rx_sum_in;
         tries_ff    <= tries_in;
         tick_ff     <= tick_in;
         fill_ff     <= fill_in;
         offset_ff   <= offset_in;
         cursor_ff   <= cursor_in;
      end
   end

endmodule

>>> src/xte_rsp_stage.sv
`timescale 1ns / 1ps

module xte_rsp_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  xte_pkg::rsp_rec_type rec,
   input  logic [7:0]           mem_rd_data,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_tx_valid,
   output logic [7:0]           rsp_tx_data,
   output logic                 rsp_last,
   output logic [2:0]           rsp_event_res,
   output logic [31:0]          rsp_block_address,
   output logic [7:0]           rsp_read_data,
   output logic                 rsp_accepted,
   output logic                 rsp_busy_res
);
   import xte_pkg::*;

   // Second stage: waits for the block store read data.
   logic        s2_valid_ff;
   rsp_rec_type s2_ff;

   // Frame checksum of the sender, summed as data bytes leave.
   logic [7:0] tx_sum_ff;

   // Output register.
   logic        out_valid_ff;
   logic        second_ff;
   logic        tx_valid_ff;
   logic [7:0]  tx_data_ff;
   logic        last_ff;
   logic [2:0]  event_ff;
   logic [31:0] addr_ff;
   logic [7:0]  read_data_ff;
   logic        accepted_ff;
   logic        busy_ff;

   logic       out_free;
   logic       s2_move;
   logic [7:0] s2_tx_data;

   assign out_free  = !out_valid_ff || (rsp_ready && !second_ff);
   assign s2_move   = s2_valid_ff && out_free;
   assign req_ready = !s2_valid_ff || out_free;

   // Line byte of the item in the second stage.
   always_comb begin
      case (s2_ff.tx_sel)
         TXS_BYTE: s2_tx_data = s2_ff.tx_byte;
         TXS_DATA: s2_tx_data = mem_rd_data;
         TXS_SUM:  s2_tx_data = tx_sum_ff;
         default:  s2_tx_data = '0;
      endcase
   end

   // Second stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (accept) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_move) begin
         s2_valid_ff <= 1'b0;
      end
   end

   // Second stage payload and checksum.
   always_ff @(posedge clock) begin
      if (accept) begin
         s2_ff <= rec;
      end
      if (s2_move) begin
         if (s2_ff.sum_clear) begin
            tx_sum_ff <= '0;
         end else if (s2_ff.tx_sel == TXS_DATA) begin
            tx_sum_ff <= tx_sum_ff + mem_rd_data;
         end
      end
   end

   // Output control: a refused block holds the register for a second CAN.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else if (s2_move) begin
         out_valid_ff <= 1'b1;
         second_ff    <= s2_ff.dual;
      end else if (out_valid_ff && rsp_ready) begin
         if (second_ff) begin
            second_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (s2_move) begin
         tx_valid_ff  <= (s2_ff.tx_sel != TXS_NONE);
         tx_data_ff   <= s2_tx_data;
         last_ff      <= s2_ff.last && !s2_ff.dual;
         event_ff     <= s2_ff.ev;
         addr_ff      <= s2_ff.addr;
         read_data_ff <= s2_ff.rd_sel ? mem_rd_data : 8'd0;
         accepted_ff  <= s2_ff.accepted;
         busy_ff      <= s2_ff.busy;
      end else if (out_valid_ff && rsp_ready && second_ff) begin
         last_ff <= 1'b1;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_tx_data       = tx_data_ff;
   assign rsp_last          = last_ff;
   assign rsp_event_res     = event_ff;
   assign rsp_block_address = addr_ff;
   assign rsp_read_data     = read_data_ff;
   assign rsp_accepted      = accepted_ff;
   assign rsp_busy_res      = busy_ff;

endmodule

>>> src/xmodem_transfer_engine_top.sv
`timescale 1ns / 1ps
// XMODEM transfer engine (8-bit checksum, 128-byte blocks), receiver or sender.
// Request channel (req_*): one item per action: start a receive or send
// session, a line byte, a tick, a pull of the next frame byte, a block buffer
// write or read, or the application's verdict. Response channel (rsp_*):
// one result per item, two for a refused block (CAN, CAN); rsp_last marks
// the final result of an item, or the checksum byte of a pulled frame.
// Configuration port (csr_*): registers 0 NAK interval, 1 NAK tries,
// 2 sender start ticks; always ready. They are to be written while the
// engine is idle; the block itself leaves this to the user.
// The first result of an item is registered in the block buffer read stage,
// then in the output register.
// Throughput: one item per cycle while the receiver takes results; a refused
// block holds the output register for a second result. The 128 x 8 block
// buffer has one write and one read port, and each item touches it at most once.
// Reset clears the session (engine off) and loads the register defaults;
// buffer contents are undefined until written.
// When the receiver stalls, results wait in the output register while one
// more item is accepted into the read stage; then req_ready drops.
module xmodem_transfer_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_line_data,
   input  logic        req_app_ok,
   input  logic [6:0]  req_buf_index,
   input  logic [7:0]  req_buf_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_data,
   output logic        rsp_last,
   output logic [2:0]  rsp_event_res,
   output logic [31:0] rsp_block_address,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_accepted,
   output logic        rsp_busy_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import xte_pkg::*;

   logic        accept;
   rsp_rec_type rec;
   mem_cmd_type mem_cmd;
   logic [7:0]  mem_rd_data;

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   xte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .line_data (req_line_data),
      .app_ok    (req_app_ok),
      .buf_index (req_buf_index),
      .buf_data  (req_buf_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rec       (rec),
      .mem_cmd   (mem_cmd)
   );

   xte_block_ram u_ram (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (mem_rd_data)
   );

   xte_rsp_stage u_rsp (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .rec               (rec),
      .mem_rd_data       (mem_rd_data),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_data       (rsp_tx_data),
      .rsp_last          (rsp_last),
      .rsp_event_res     (rsp_event_res),
      .rsp_block_address (rsp_block_address),
      .rsp_read_data     (rsp_read_data),
      .rsp_accepted      (rsp_accepted),
      .rsp_busy_res      (rsp_busy_res)
   );

endmodule

>>> src/xte_checker.sv
`timescale 1ns / 1ps

module xte_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_tx_valid,
   input logic [7:0]  rsp_tx_data,
   input logic        rsp_last,
   input logic [2:0]  rsp_event_res,
   input logic [31:0] rsp_block_address,
   input logic        rsp_accepted,
   input logic        rsp_busy_res
);
   import xte_pkg::*;

   // A stalled result item stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_data) && $stable(rsp_last))
      else $error("stalled response changed");

   // A result without a line byte carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_data == 8'd0)
      else $error("tx_data set without tx_valid");

   // Only block events carry a block address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_RECEIVED && rsp_event_res != EV_NEEDED
      |-> rsp_block_address == 32'd0)
      else $error("block address without block event");

   // A result that is not last always carries a line byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_tx_valid)
      else $error("non-final result without line byte");

   // A refused line byte leaves the engine off with no event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> !rsp_busy_res && rsp_event_res == EV_NONE)
      else $error("refused line byte with session activity");

endmodule

bind xmodem_transfer_engine_top xte_checker u_checker (.*);
